### src/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and constants of the i2c master byte sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

   localparam logic [15:0] UNIT_TICKS_RESET     = 16'd100;
   localparam logic [15:0] ACK_POLL_LIMIT_RESET = 16'd1000;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_UNIT_TICKS     = 1'b0,
      CSR_ACK_POLL_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] unit_ticks;
      logic [15:0] ack_poll_limit;
   } cfg_type;

   typedef struct packed {
      logic       cmd_valid;
      opcode_type opcode;
      logic [7:0] tx_byte;
      logic       send_nack;
      logic       sda_in;
   } req_fields_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_error;
   } rsp_fields_type;

endpackage

### src/i2cms_req_if.sv
// ----------------------------------------------------------------------------
// i2cms_req_if
// tick channel into the sequencer: one transfer per bus tick
// ----------------------------------------------------------------------------
interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [1:0] opcode;
   logic [7:0] tx_byte;
   logic       send_nack;
   logic       sda_in;

   modport source (output valid, cmd_valid, opcode, tx_byte, send_nack, sda_in,
                   input ready);
   modport sink   (input valid, cmd_valid, opcode, tx_byte, send_nack, sda_in,
                   output ready);
endinterface

### src/i2cms_rsp_if.sv
// ----------------------------------------------------------------------------
// i2cms_rsp_if
// result channel out of the sequencer: line levels and status per tick
// ----------------------------------------------------------------------------
interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_drive;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_error;

   modport source (output valid, scl_level, sda_drive, sda_level, busy_res,
                   done_res, rx_byte, ack_error,
                   input ready);
   modport sink   (input valid, scl_level, sda_drive, sda_level, busy_res,
                   done_res, rx_byte, ack_error,
                   output ready);
endinterface

### src/i2cms_engine.sv
// ----------------------------------------------------------------------------
// i2cms_engine
// bus sequencer state: advances one tick per step, state doubles as result
// ----------------------------------------------------------------------------
module i2cms_engine
   import i2cms_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  req_fields_type req,
   input  cfg_type        cfg,
   output rsp_fields_type rsp
);

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_ST_A, PH_ST_B, PH_ST_C,
      PH_SP_A, PH_SP_B, PH_SP_C,
      PH_WR_LO, PH_WR_HI, PH_WR_GAP,
      PH_AK_REL, PH_AK_HI, PH_AK_POLL,
      PH_RD_LO, PH_RD_HI,
      PH_RA_LO, PH_RA_H1, PH_RA_H2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  rx_ff, rx_in;
   logic [15:0] unit_cnt_ff, unit_cnt_in;
   logic [15:0] poll_cnt_ff, poll_cnt_in;
   logic        scl_ff, scl_in;
   logic        drv_ff, drv_in;
   logic        sda_ff, sda_in_lvl;
   logic        err_ff, err_in;
   logic        nack_ff, nack_in;
   logic        done_ff, done_in;

   logic [15:0] unit_eff;
   logic [15:0] unit_cnt_inc;
   logic [3:0]  bit_inc;

   assign unit_eff     = (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks;
   assign unit_cnt_inc = unit_cnt_ff + 16'd1;
   assign bit_inc      = bit_index_ff + 4'd1;

   always_comb begin
      phase_in     = phase_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      rx_in        = rx_ff;
      unit_cnt_in  = unit_cnt_ff;
      poll_cnt_in  = poll_cnt_ff;
      scl_in       = scl_ff;
      drv_in       = drv_ff;
      sda_in_lvl   = sda_ff;
      err_in       = err_ff;
      nack_in      = nack_ff;
      done_in      = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (req.cmd_valid) begin
            unit_cnt_in  = '0;
            bit_index_in = '0;
            unique case (req.opcode)
               OP_START: begin
                  scl_in     = 1'b1;
                  drv_in     = 1'b1;
                  sda_in_lvl = 1'b1;
                  phase_in   = PH_ST_A;
               end
               OP_STOP: begin
                  scl_in     = 1'b0;
                  drv_in     = 1'b1;
                  sda_in_lvl = 1'b0;
                  phase_in   = PH_SP_A;
               end
               OP_WRITE: begin
                  err_in     = 1'b0;
                  shift_in   = req.tx_byte;
                  scl_in     = 1'b0;
                  drv_in     = 1'b1;
                  sda_in_lvl = req.tx_byte[7];
                  phase_in   = PH_WR_LO;
               end
               OP_READ: begin
                  shift_in   = '0;
                  nack_in    = req.send_nack;
                  scl_in     = 1'b0;
                  drv_in     = 1'b0;
                  sda_in_lvl = 1'b1;
                  phase_in   = PH_RD_LO;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end else if (phase_ff == PH_AK_POLL) begin
         if (!req.sda_in) begin
            scl_in   = 1'b0;
            phase_in = PH_IDLE;
            done_in  = 1'b1;
         end else if (poll_cnt_ff >= cfg.ack_poll_limit) begin
            err_in      = 1'b1;
            unit_cnt_in = '0;
            scl_in      = 1'b0;
            drv_in      = 1'b1;
            sda_in_lvl  = 1'b0;
            phase_in    = PH_SP_A;
         end else begin
            poll_cnt_in = poll_cnt_ff + 16'd1;
         end
      end else begin
         unit_cnt_in = unit_cnt_inc;
         if (unit_cnt_inc >= unit_eff) begin
            unit_cnt_in = '0;
            unique case (phase_ff)
               PH_ST_A: begin
                  sda_in_lvl = 1'b0;
                  phase_in   = PH_ST_B;
               end
               PH_ST_B: phase_in = PH_ST_C;
               PH_ST_C: begin
                  scl_in   = 1'b0;
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
               PH_SP_A: begin
                  scl_in   = 1'b1;
                  phase_in = PH_SP_B;
               end
               PH_SP_B: begin
                  sda_in_lvl = 1'b1;
                  phase_in   = PH_SP_C;
               end
               PH_SP_C: begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
               PH_WR_LO: begin
                  scl_in   = 1'b1;
                  phase_in = PH_WR_HI;
               end
               PH_WR_HI: begin
                  scl_in   = 1'b0;
                  phase_in = PH_WR_GAP;
               end
               PH_WR_GAP: begin
                  bit_index_in = bit_inc;
                  if (bit_inc < 4'd8) begin
                     shift_in   = {shift_ff[6:0], 1'b0};
                     scl_in     = 1'b0;
                     drv_in     = 1'b1;
                     sda_in_lvl = shift_ff[6];
                     phase_in   = PH_WR_LO;
                  end else begin
                     scl_in     = 1'b0;
                     drv_in     = 1'b0;
                     sda_in_lvl = 1'b1;
                     phase_in   = PH_AK_REL;
                  end
               end
               PH_AK_REL: begin
                  scl_in   = 1'b1;
                  phase_in = PH_AK_HI;
               end
               PH_AK_HI: begin
                  poll_cnt_in = '0;
                  phase_in    = PH_AK_POLL;
               end
               PH_RD_LO: begin
                  scl_in   = 1'b1;
                  phase_in = PH_RD_HI;
               end
               PH_RD_HI: begin
                  shift_in     = {shift_ff[6:0], req.sda_in};
                  bit_index_in = bit_inc;
                  if (bit_inc < 4'd8) begin
                     scl_in   = 1'b0;
                     phase_in = PH_RD_LO;
                  end else begin
                     scl_in     = 1'b0;
                     drv_in     = 1'b1;
                     sda_in_lvl = nack_ff;
                     phase_in   = PH_RA_LO;
                  end
               end
               PH_RA_LO: begin
                  scl_in   = 1'b1;
                  phase_in = PH_RA_H1;
               end
               PH_RA_H1: phase_in = PH_RA_H2;
               PH_RA_H2: begin
                  scl_in   = 1'b0;
                  rx_in    = shift_ff;
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_index_ff <= '0;
         shift_ff     <= '0;
         rx_ff        <= '0;
         unit_cnt_ff  <= '0;
         poll_cnt_ff  <= '0;
         scl_ff       <= 1'b1;
         drv_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         err_ff       <= 1'b0;
         nack_ff      <= 1'b0;
         done_ff      <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         rx_ff        <= rx_in;
         unit_cnt_ff  <= unit_cnt_in;
         poll_cnt_ff  <= poll_cnt_in;
         scl_ff       <= scl_in;
         drv_ff       <= drv_in;
         sda_ff       <= sda_in_lvl;
         err_ff       <= err_in;
         nack_ff      <= nack_in;
         done_ff      <= done_in;
      end
   end

   assign rsp.scl_level = scl_ff;
   assign rsp.sda_drive = drv_ff;
   assign rsp.sda_level = sda_ff;
   assign rsp.busy_res  = (phase_ff != PH_IDLE);
   assign rsp.done_res  = done_ff;
   assign rsp.rx_byte   = rx_ff;
   assign rsp.ack_error = err_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (phase_ff == PH_IDLE))
      else $error("done without return to idle");

   a_idle_unit_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (unit_cnt_ff == 16'd0))
      else $error("unit counter not cleared in idle");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= 4'd8)
      else $error("bit index past byte end");

   a_err_from_poll: assert property (@(posedge clock) disable iff (reset)
      $rose(err_ff) |-> ($past(phase_ff) == PH_AK_POLL && phase_ff == PH_SP_A))
      else $error("ack error set outside polling");

   a_poll_released: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_AK_POLL) |-> (!drv_ff && scl_ff))
      else $error("sda driven during ack poll");

endmodule

### src/i2c_master_byte_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_top
// i2c master byte sequencer: start, stop, byte write with ack poll, byte read
//
// each transfer on req_if is one bus tick: it carries the sampled sda level
// and, while the sequencer is idle, an optional command. every accepted tick
// yields exactly one transfer on rsp_if with the scl/sda line state, busy,
// a one-tick done pulse, the last read byte and the ack error flag.
// rsp valid follows in the cycle after req acceptance; one tick is taken every
// cycle unless rsp_if stalls, set by the sequencer's single registered update.
// the result register frees up in the same cycle it is taken, so a stalled
// rsp_if holds its result and stops req_if only while it stays full.
// csr writes (csr_we, csr_index, csr_wdata) set the delay unit in ticks and
// the ack poll limit; they take effect on the next tick.
// reset: scl high, sda driven high, idle, unit 100 ticks, poll limit 1000,
// no result pending.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer_top
   import i2cms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   i2cms_req_if.sink    req_if,
   i2cms_rsp_if.source  rsp_if,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   cfg_type        cfg_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_ready;
   logic           step;
   req_fields_type req;
   rsp_fields_type rsp;

   assign req_ready    = !rsp_valid_ff || rsp_if.ready;
   assign step         = req_if.valid && req_ready;
   assign req_if.ready = req_ready;

   assign req.cmd_valid = req_if.cmd_valid;
   assign req.opcode    = opcode_type'(req_if.opcode);
   assign req.tx_byte   = req_if.tx_byte;
   assign req.send_nack = req_if.send_nack;
   assign req.sda_in    = req_if.sda_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff          <= 1'b0;
         cfg_ff.unit_ticks     <= UNIT_TICKS_RESET;
         cfg_ff.ack_poll_limit <= ACK_POLL_LIMIT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_UNIT_TICKS:     cfg_ff.unit_ticks     <= csr_wdata;
               CSR_ACK_POLL_LIMIT: cfg_ff.ack_poll_limit <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   i2cms_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req),
      .cfg   (cfg_ff),
      .rsp   (rsp)
   );

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.scl_level = rsp.scl_level;
   assign rsp_if.sda_drive = rsp.sda_drive;
   assign rsp_if.sda_level = rsp.sda_level;
   assign rsp_if.busy_res  = rsp.busy_res;
   assign rsp_if.done_res  = rsp.done_res;
   assign rsp_if.rx_byte   = rsp.rx_byte;
   assign rsp_if.ack_error = rsp.ack_error;

endmodule

### dv/tb_i2c_master_byte_sequencer_top.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_sequencer_top
// self-checking bench for the i2c master byte sequencer
//
// every bus tick sent on req_if is run through a cycle-true model of the
// sequencer kept in this bench; the predicted line levels and status are
// queued and compared field by field with each transfer taken on rsp_if.
// directed tests cover start, stop, writes with ack, ack timeout, reads with
// ack and nack, busy commands and the extreme delay and poll settings; then
// random commands run under four mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_sequencer_top
   import i2cms_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 5;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int REPORT_MAX     = 10;
   localparam int RANDOM_TICKS   = 35;

   typedef enum logic [4:0] {
      SEQ_IDLE, SEQ_ST_A, SEQ_ST_B, SEQ_ST_C, SEQ_SP_A, SEQ_SP_B, SEQ_SP_C,
      SEQ_WR_LO, SEQ_WR_HI, SEQ_WR_GAP, SEQ_AK_REL, SEQ_AK_HI, SEQ_AK_POLL,
      SEQ_RD_LO, SEQ_RD_HI, SEQ_RA_LO, SEQ_RA_H1, SEQ_RA_H2
   } seq_phase_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;

   i2cms_req_if req_if ();
   i2cms_rsp_if rsp_if ();

   i2c_master_byte_sequencer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // sequencer model state
   cfg_type       cfg       = '{UNIT_TICKS_RESET, ACK_POLL_LIMIT_RESET};
   seq_phase_type seq_phase = SEQ_IDLE;
   logic [3:0]    bit_cnt   = '0;
   logic [7:0]    shift_q   = '0;
   logic [7:0]    rx_q      = '0;
   logic [15:0]   unit_cnt  = '0;
   logic [15:0]   poll_cnt  = '0;
   logic          line_scl  = 1'b1;
   logic          line_drv  = 1'b1;
   logic          line_sda  = 1'b1;
   logic          err_flag  = 1'b0;
   logic          nack_q    = 1'b0;

   rsp_fields_type expected_lines[$];

   // stimulus knobs
   int         send_idle_pct  = 0;
   int         recv_stall_pct = 0;
   int         noise_pct      = 0;
   int         ack_wait       = 0;
   logic [7:0] slave_byte     = '0;

   int commands_run    = 0;
   int ticks_sent      = 0;
   int results_checked = 0;
   int mismatches      = 0;
   int quiet_cycles    = 0;

   initial begin
      clock = 1'b0;
      forever #(HALF_PERIOD) clock = ~clock;
   end

   function automatic void set_lines(logic scl, logic drv, logic sda);
      line_scl = scl;
      line_drv = drv;
      line_sda = sda;
   endfunction

   function automatic logic [15:0] unit_len();
      return (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks;
   endfunction

   function automatic rsp_fields_type bus_tick(req_fields_type t);
      rsp_fields_type r;
      logic           fin;
      fin = 1'b0;
      if (seq_phase == SEQ_IDLE) begin
         if (t.cmd_valid) begin
            unit_cnt = '0;
            bit_cnt  = '0;
            case (t.opcode)
               OP_START: begin
                  set_lines(1'b1, 1'b1, 1'b1);
                  seq_phase = SEQ_ST_A;
               end
               OP_STOP: begin
                  set_lines(1'b0, 1'b1, 1'b0);
                  seq_phase = SEQ_SP_A;
               end
               OP_WRITE: begin
                  err_flag = 1'b0;
                  shift_q  = t.tx_byte;
                  set_lines(1'b0, 1'b1, shift_q[7]);
                  seq_phase = SEQ_WR_LO;
               end
               default: begin
                  shift_q = '0;
                  nack_q  = t.send_nack;
                  set_lines(1'b0, 1'b0, 1'b1);
                  seq_phase = SEQ_RD_LO;
               end
            endcase
         end
      end else if (seq_phase == SEQ_AK_POLL) begin
         if (!t.sda_in) begin
            line_scl  = 1'b0;
            seq_phase = SEQ_IDLE;
            fin       = 1'b1;
         end else if (poll_cnt >= cfg.ack_poll_limit) begin
            // no ack within the limit: send a stop and flag it
            err_flag = 1'b1;
            unit_cnt = '0;
            set_lines(1'b0, 1'b1, 1'b0);
            seq_phase = SEQ_SP_A;
         end else begin
            poll_cnt = poll_cnt + 16'd1;
         end
      end else begin
         unit_cnt = unit_cnt + 16'd1;
         if (unit_cnt >= unit_len()) begin
            unit_cnt = '0;
            case (seq_phase)
               SEQ_ST_A: begin
                  line_sda  = 1'b0;
                  seq_phase = SEQ_ST_B;
               end
               SEQ_ST_B: seq_phase = SEQ_ST_C;
               SEQ_ST_C: begin
                  line_scl  = 1'b0;
                  seq_phase = SEQ_IDLE;
                  fin       = 1'b1;
               end
               SEQ_SP_A: begin
                  line_scl  = 1'b1;
                  seq_phase = SEQ_SP_B;
               end
               SEQ_SP_B: begin
                  line_sda  = 1'b1;
                  seq_phase = SEQ_SP_C;
               end
               SEQ_SP_C: begin
                  seq_phase = SEQ_IDLE;
                  fin       = 1'b1;
               end
               SEQ_WR_LO: begin
                  line_scl  = 1'b1;
                  seq_phase = SEQ_WR_HI;
               end
               SEQ_WR_HI: begin
                  line_scl  = 1'b0;
                  seq_phase = SEQ_WR_GAP;
               end
               SEQ_WR_GAP: begin
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt < 4'd8) begin
                     shift_q = shift_q << 1;
                     set_lines(1'b0, 1'b1, shift_q[7]);
                     seq_phase = SEQ_WR_LO;
                  end else begin
                     set_lines(1'b0, 1'b0, 1'b1);
                     seq_phase = SEQ_AK_REL;
                  end
               end
               SEQ_AK_REL: begin
                  line_scl  = 1'b1;
                  seq_phase = SEQ_AK_HI;
               end
               SEQ_AK_HI: begin
                  poll_cnt  = '0;
                  seq_phase = SEQ_AK_POLL;
               end
               SEQ_RD_LO: begin
                  line_scl  = 1'b1;
                  seq_phase = SEQ_RD_HI;
               end
               SEQ_RD_HI: begin
                  shift_q = {shift_q[6:0], t.sda_in};
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt < 4'd8) begin
                     line_scl  = 1'b0;
                     seq_phase = SEQ_RD_LO;
                  end else begin
                     set_lines(1'b0, 1'b1, nack_q);
                     seq_phase = SEQ_RA_LO;
                  end
               end
               SEQ_RA_LO: begin
                  line_scl  = 1'b1;
                  seq_phase = SEQ_RA_H1;
               end
               SEQ_RA_H1: seq_phase = SEQ_RA_H2;
               SEQ_RA_H2: begin
                  line_scl  = 1'b0;
                  rx_q      = shift_q;
                  seq_phase = SEQ_IDLE;
                  fin       = 1'b1;
               end
               default: seq_phase = SEQ_IDLE;
            endcase
         end
      end
      r.scl_level = line_scl;
      r.sda_drive = line_drv;
      r.sda_level = line_sda;
      r.busy_res  = (seq_phase != SEQ_IDLE);
      r.done_res  = fin;
      r.rx_byte   = rx_q;
      r.ack_error = err_flag;
      return r;
   endfunction

   // slave side of sda: ack after ack_wait polls, read data on the sampling tick
   function automatic logic slave_sda();
      if (seq_phase == SEQ_AK_POLL)
         return (int'(poll_cnt) >= ack_wait) ? 1'b0 : 1'b1;
      if (seq_phase == SEQ_RD_HI && int'(unit_cnt) + 1 >= int'(unit_len()))
         return slave_byte[3'd7 - bit_cnt[2:0]];
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic send_tick(input logic cmd, input opcode_type op,
                            input logic [7:0] tx, input logic nk);
      req_fields_type t;
      t.cmd_valid = cmd;
      t.opcode    = op;
      t.tx_byte   = tx;
      t.send_nack = nk;
      t.sda_in    = slave_sda();
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.cmd_valid <= t.cmd_valid;
      req_if.opcode    <= t.opcode;
      req_if.tx_byte   <= t.tx_byte;
      req_if.send_nack <= t.send_nack;
      req_if.sda_in    <= t.sda_in;
      do @(posedge clock); while (!req_if.ready);
      expected_lines.push_back(bus_tick(t));
      ticks_sent++;
   endtask

   task automatic filler_tick();
      logic busy;
      busy = (seq_phase != SEQ_IDLE);
      send_tick(busy && ($urandom_range(0, 99) < noise_pct),
                opcode_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
   endtask

   task automatic run_command(input opcode_type op, input logic [7:0] tx,
                              input logic nk, input int aw, input logic [7:0] rd);
      ack_wait   = aw;
      slave_byte = rd;
      send_tick(1'b1, op, tx, nk);
      commands_run++;
      while (seq_phase != SEQ_IDLE)
         filler_tick();
   endtask

   task automatic rand_command(input opcode_type op);
      int aw;
      if ($urandom_range(0, 99) < 70)
         aw = $urandom_range(0, 2);
      else
         aw = $urandom_range(0, int'(cfg.ack_poll_limit) + 2);
      run_command(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), aw,
                  8'($urandom_range(0, 255)));
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (expected_lines.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_UNIT_TICKS)
         cfg.unit_ticks = value;
      else
         cfg.ack_poll_limit = value;
      @(posedge clock);
   endtask

   // start held for some ticks at the current unit, then finished at one tick
   task automatic start_then_shorten(input int hold_ticks);
      ack_wait   = 0;
      slave_byte = '0;
      send_tick(1'b1, OP_START, 8'h00, 1'b0);
      commands_run++;
      repeat (hold_ticks)
         filler_tick();
      write_csr(CSR_UNIT_TICKS, 16'd1);
      while (seq_phase != SEQ_IDLE)
         filler_tick();
   endtask

   task automatic test_reset_defaults();
      start_then_shorten(30);
   endtask

   task automatic test_zero_unit();
      write_csr(CSR_UNIT_TICKS, 16'd0);
      run_command(OP_WRITE, 8'hC3, 1'b0, 1, 8'h00);
      run_command(OP_STOP, 8'h00, 1'b0, 0, 8'h00);
   endtask

   task automatic test_write_ack();
      write_csr(CSR_UNIT_TICKS, 16'd1);
      write_csr(CSR_ACK_POLL_LIMIT, 16'd2);
      // ack on the last poll allowed
      run_command(OP_WRITE, 8'hA5, 1'b0, 2, 8'h00);
   endtask

   task automatic test_ack_timeout();
      run_command(OP_WRITE, 8'h5A, 1'b0, 3, 8'h00);
   endtask

   task automatic test_widest_poll_limit();
      write_csr(CSR_ACK_POLL_LIMIT, 16'hFFFF);
      // a new write clears the error flag
      run_command(OP_WRITE, 8'h81, 1'b0, 1, 8'h00);
   endtask

   task automatic test_read_byte();
      write_csr(CSR_UNIT_TICKS, 16'd2);
      run_command(OP_READ, 8'h00, 1'b1, 0, 8'h5A);
   endtask

   task automatic test_busy_commands();
      write_csr(CSR_UNIT_TICKS, 16'd1);
      noise_pct = 100;
      run_command(OP_READ, 8'h00, 1'b0, 0, 8'hC3);
      noise_pct = 0;
   endtask

   task automatic test_widest_unit();
      write_csr(CSR_UNIT_TICKS, 16'hFFFF);
      start_then_shorten(20);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int unit, input int tick_budget);
      int goal;
      int n;
      write_csr(CSR_UNIT_TICKS, 16'(unit));
      write_csr(CSR_ACK_POLL_LIMIT, 16'($urandom_range(1, 4)));
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      noise_pct      = 10;
      goal = ticks_sent + tick_budget;
      while (ticks_sent < goal) begin
         rand_command(opcode_type'($urandom_range(0, 3)));
         n = $urandom_range(0, 2);
         repeat (n)
            filler_tick();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      noise_pct      = 0;
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("mismatch on %s in result %0d: expected %0h, got %0h",
                     name, results_checked, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_fields_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_lines.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("result %0d arrived with nothing expected", results_checked);
         end else begin
            want = expected_lines.pop_front();
            check_field("scl_level", 8'(want.scl_level), 8'(rsp_if.scl_level));
            check_field("sda_drive", 8'(want.sda_drive), 8'(rsp_if.sda_drive));
            check_field("sda_level", 8'(want.sda_level), 8'(rsp_if.sda_level));
            check_field("busy_res", 8'(want.busy_res), 8'(rsp_if.busy_res));
            check_field("done_res", 8'(want.done_res), 8'(rsp_if.done_res));
            check_field("rx_byte", want.rx_byte, rsp_if.rx_byte);
            check_field("ack_error", 8'(want.ack_error), 8'(rsp_if.ack_error));
         end
         results_checked++;
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= CSR_UNIT_TICKS;
      csr_wdata        <= '0;
      req_if.valid     <= 1'b0;
      req_if.cmd_valid <= 1'b0;
      req_if.opcode    <= OP_START;
      req_if.tx_byte   <= '0;
      req_if.send_nack <= 1'b0;
      req_if.sda_in    <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_unit();
      test_write_ack();
      test_ack_timeout();
      test_widest_poll_limit();
      test_read_byte();
      test_busy_commands();
      test_widest_unit();
      test_random_traffic(0, 0, 1, RANDOM_TICKS);
      test_random_traffic(85, 0, 2, RANDOM_TICKS);
      test_random_traffic(0, 85, 1, RANDOM_TICKS);
      test_random_traffic(38, 38, $urandom_range(1, 2), RANDOM_TICKS);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d commands over %0d bus ticks, %0d results checked, %0d mismatches",
               commands_run, ticks_sent, results_checked, mismatches);
      $display("%0d results never arrived", expected_lines.size());
      $display("covered start, stop, write with ack and timeout, read with ack and nack,");
      $display("busy commands, delay units 0 to 65535, poll limit up to 65535, four flow mixes");
      if (mismatches == 0 && expected_lines.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
